/* hw/rtl/amfm_pkg.sv */
// ----------------------------------------------------------------------------
// amfm_pkg
// shared types, register codes, constants and the sine table generator for
// the am / fm tone modulator
// ----------------------------------------------------------------------------
`default_nettype none

package amfm_pkg;

    // default parameter values
    localparam int PHASE_BITS_DEF       = 32;
    localparam int SINE_ADDR_BITS_DEF   = 10;
    localparam int INDEX_BITS_DEF       = 20;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MODE_SELECT  = 2'd0,
        REG_MOD_INDEX    = 2'd1,
        REG_CARRIER_STEP = 2'd2,
        REG_MESSAGE_STEP = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        MODE_AM = 1'b0,
        MODE_FM = 1'b1
    } mode_t;

    // field and datapath widths
    localparam int STEP_W = 32;
    localparam int K_W    = 17;
    localparam int ROM_W  = 16;
    localparam int SINE_W = 17;
    localparam int MSG_W  = 18;
    localparam int KM_W   = 35;
    localparam int MAG_W  = 33;
    localparam int INV_W  = 30;
    localparam int FMP_W  = 63;
    localparam int AMB_W  = 36;
    localparam int AMP_W  = 53;
    localparam int OUT_W  = 24;

    // register reset values
    localparam mode_t             MODE_RESET  = MODE_AM;
    localparam logic [K_W-1:0]    K_RESET     = 17'd655;
    localparam logic [STEP_W-1:0] CSTEP_RESET = 32'd214748365;
    localparam logic [STEP_W-1:0] MSTEP_RESET = 32'd21474836;

    // arithmetic constants
    localparam logic [INV_W-1:0] INV_TWO_PI_Q32 = 30'd683565276;
    localparam int FM_SHIFT_BASE = 57;
    localparam int AM_SHIFT      = 25;
    localparam int OUT_MAX       = 8388607;
    localparam int OUT_MIN       = -8388608;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned SERIES_DIV [7] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
    };

    // quarter-wave table entry j, q30 taylor series rounded to q15
    function automatic logic [ROM_W-1:0] sine_entry(input int unsigned j,
                                                    input int unsigned addr_bits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint unsigned rounded;
        int              k;
        x    = ((64'd2 * 64'(j) + 64'd1) * HALF_PI_Q30) >> (addr_bits + 1);
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (k = 1; k <= 7; k++)
        begin
            term = (term * x2) >> 30;
            term = term / SERIES_DIV[k-1];
            if ((k & 1) == 1)
            begin
                sum = sum - $signed(term);
            end
            else
            begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        rounded = ($unsigned(sum) + 64'd16384) >> 15;
        return rounded[ROM_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/am_fm_tone_modulator.sv */
// ----------------------------------------------------------------------------
// am_fm_tone_modulator
// am / fm modulator with a sinusoidal message tone, one sample per request
// ----------------------------------------------------------------------------
// usage:
//   input channel  in_valid / in_ready carries sample_index n
//   output channel out_valid / out_ready carries modulated_sample (q8.15,
//   saturated) and the saturated flag
//   config channel cfg_valid / cfg_ready writes mode_select, mod_index,
//   carrier_step and message_step by index; cfg_ready is always high; the
//   user must make writes only while no request is in flight (the block does not enforce it)
// stages: nine register stages, s1 to s8 and then the output register, which a
//   request passes through in order
// throughput: one request per cycle while out_ready holds high; every stage
//   has its own load enable and no value feeds back from one request to the next
// reset: all stage valid bits clear, configuration registers take their reset values
//   (am mode, k = 655, default carrier and message steps)
// stall: while out_ready is low, stages fill bubble by bubble and in_ready
//   drops only once every stage holds a request; nothing is lost or repeated
// ----------------------------------------------------------------------------
`default_nettype none

module am_fm_tone_modulator #(
    parameter int PHASE_BITS           = amfm_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_ADDR_BITS = amfm_pkg::SINE_ADDR_BITS_DEF,
    parameter int INDEX_BITS           = amfm_pkg::INDEX_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                in_valid,
    output      logic                                in_ready,
    input  wire logic [INDEX_BITS-1:0]               sample_index,

    output      logic                                out_valid,
    input  wire logic                                out_ready,
    output      logic signed [amfm_pkg::OUT_W-1:0]   modulated_sample,
    output      logic                                saturated,

    input  wire logic                                cfg_valid,
    output      logic                                cfg_ready,
    input  wire logic [amfm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [amfm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import amfm_pkg::*;

    localparam int NSTAGE   = 9;
    localparam int ROM_LEN  = 1 << SINE_TABLE_ADDR_BITS;
    localparam int MUL_W    = (INDEX_BITS + STEP_W > PHASE_BITS) ?
                              (INDEX_BITS + STEP_W) : PHASE_BITS;
    localparam int FM_SHIFT = FM_SHIFT_BASE - PHASE_BITS;
    localparam logic [PHASE_BITS-1:0] QUARTER = PHASE_BITS'(1) << (PHASE_BITS - 2);
    localparam logic [63:0] FM_ROUND = 64'd1 << (FM_SHIFT - 1);
    localparam logic signed [AMB_W-1:0] AM_ONE = AMB_W'(1) <<< AM_SHIFT;
    localparam logic signed [AMP_W-1:0] AM_ROUND = AMP_W'(1) <<< (AM_SHIFT - 1);
    localparam logic signed [AMP_W-1:0] Y_MAX = AMP_W'(OUT_MAX);
    localparam logic signed [AMP_W-1:0] Y_MIN = AMP_W'(OUT_MIN);

    typedef logic [ROM_W-1:0] rom_t [ROM_LEN];

    function automatic rom_t build_rom();
        rom_t r;
        for (int j = 0; j < ROM_LEN; j++)
        begin
            r[j] = sine_entry(unsigned'(j), unsigned'(SINE_TABLE_ADDR_BITS));
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // configuration registers
    mode_t                    mode_reg;
    logic signed [K_W-1:0]    k_reg;
    logic [STEP_W-1:0]        cstep_reg;
    logic [STEP_W-1:0]        mstep_reg;

    // pipeline control
    logic [NSTAGE:1]          v_reg;
    logic [NSTAGE:1]          en;

    // stage data
    logic [INDEX_BITS-1:0]       s1_n_reg;
    logic [PHASE_BITS-1:0]       s2_pc_reg;
    logic [PHASE_BITS-1:0]       s2_pm_reg;
    logic [PHASE_BITS-1:0]       s3_pcq_reg;
    logic [ROM_W-1:0]            s3_mrom_reg;
    logic                        s3_mneg_reg;
    logic [PHASE_BITS-1:0]       s4_pcq_reg;
    logic signed [KM_W-1:0]      s4_km_reg;
    logic [PHASE_BITS-1:0]       s5_pcq_reg;
    logic signed [KM_W-1:0]      s5_km_reg;
    logic [FMP_W-1:0]            s5_prod_reg;
    logic [PHASE_BITS-1:0]       s6_phase_reg;
    logic signed [KM_W-1:0]      s6_km_reg;
    logic [ROM_W-1:0]            s7_crom_reg;
    logic                        s7_cneg_reg;
    logic signed [KM_W-1:0]      s7_km_reg;
    logic signed [AMP_W-1:0]     s8_am_reg;
    logic signed [SINE_W-1:0]    s8_c_reg;
    logic signed [OUT_W-1:0]     out_sample_reg;
    logic                        out_sat_reg;

    // combinational stage values
    logic [MUL_W-1:0]            pc_full;
    logic [MUL_W-1:0]            pm_full;
    logic [1:0]                  mq;
    logic [SINE_TABLE_ADDR_BITS-1:0] ma;
    logic [SINE_TABLE_ADDR_BITS-1:0] maddr_next;
    logic signed [MSG_W-1:0]     m2;
    logic signed [MSG_W-1:0]     mval;
    logic signed [KM_W-1:0]      km_next;
    logic [KM_W-1:0]             magw;
    logic [FMP_W-1:0]            prod_next;
    logic [63:0]                 d_full;
    logic [PHASE_BITS-1:0]       d_ph;
    logic [PHASE_BITS-1:0]       phase_next;
    logic [1:0]                  cq;
    logic [SINE_TABLE_ADDR_BITS-1:0] ca;
    logic [SINE_TABLE_ADDR_BITS-1:0] caddr_next;
    logic signed [SINE_W-1:0]    c_next;
    logic signed [AMB_W-1:0]     kmb;
    logic signed [AMP_W-1:0]     am_next;
    logic signed [AMP_W-1:0]     y_am;
    logic signed [AMP_W-1:0]     y_sel;
    logic signed [OUT_W-1:0]     sample_next;
    logic                        sat_next;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_RESET;
            k_reg     <= K_RESET;
            cstep_reg <= CSTEP_RESET;
            mstep_reg <= MSTEP_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MODE_SELECT:  mode_reg  <= mode_t'(cfg_data[0]);
                REG_MOD_INDEX:    k_reg     <= cfg_data[K_W-1:0];
                REG_CARRIER_STEP: cstep_reg <= cfg_data[STEP_W-1:0];
                REG_MESSAGE_STEP: mstep_reg <= cfg_data[STEP_W-1:0];
                default:          mode_reg  <= mode_reg;
            endcase
        end
    end

    // per-stage load enables, bubbles collapse
    always_comb
    begin
        en[NSTAGE] = !v_reg[NSTAGE] || out_ready;
        for (int i = NSTAGE - 1; i >= 1; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign in_ready = en[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                v_reg[1] <= in_valid;
            end
            for (int i = 2; i <= NSTAGE; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // datapath
    always_comb
    begin
        pc_full    = MUL_W'(s1_n_reg) * MUL_W'(cstep_reg);
        pm_full    = MUL_W'(s1_n_reg) * MUL_W'(mstep_reg);

        mq         = s2_pm_reg[PHASE_BITS-1 -: 2];
        ma         = s2_pm_reg[PHASE_BITS-3 -: SINE_TABLE_ADDR_BITS];
        maddr_next = mq[0] ? ~ma : ma;

        m2         = $signed({1'b0, s3_mrom_reg, 1'b0});
        mval       = s3_mneg_reg ? -m2 : m2;
        km_next    = KM_W'(k_reg) * KM_W'(mval);

        magw       = s4_km_reg[KM_W-1] ? $unsigned(-s4_km_reg) : $unsigned(s4_km_reg);
        prod_next  = FMP_W'(magw[MAG_W-1:0]) * FMP_W'(INV_TWO_PI_Q32);

        d_full     = (64'(s5_prod_reg) + FM_ROUND) >> FM_SHIFT;
        d_ph       = d_full[PHASE_BITS-1:0];
        if (mode_reg == MODE_FM)
        begin
            phase_next = s5_km_reg[KM_W-1] ? (s5_pcq_reg - d_ph) : (s5_pcq_reg + d_ph);
        end
        else
        begin
            phase_next = s5_pcq_reg;
        end

        cq         = s6_phase_reg[PHASE_BITS-1 -: 2];
        ca         = s6_phase_reg[PHASE_BITS-3 -: SINE_TABLE_ADDR_BITS];
        caddr_next = cq[0] ? ~ca : ca;

        c_next     = s7_cneg_reg ? -$signed({1'b0, s7_crom_reg}) :
                                   $signed({1'b0, s7_crom_reg});
        kmb        = AMB_W'(s7_km_reg) + AM_ONE;
        am_next    = AMP_W'(kmb) * AMP_W'(c_next);

        y_am       = (s8_am_reg + AM_ROUND) >>> AM_SHIFT;
        y_sel      = (mode_reg == MODE_FM) ? AMP_W'(s8_c_reg) : y_am;
        if (y_sel > Y_MAX)
        begin
            sample_next = OUT_W'(OUT_MAX);
            sat_next    = 1'b1;
        end
        else if (y_sel < Y_MIN)
        begin
            sample_next = OUT_W'(OUT_MIN);
            sat_next    = 1'b1;
        end
        else
        begin
            sample_next = y_sel[OUT_W-1:0];
            sat_next    = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_n_reg <= sample_index;
        end
        if (en[2])
        begin
            s2_pc_reg <= pc_full[PHASE_BITS-1:0];
            s2_pm_reg <= pm_full[PHASE_BITS-1:0];
        end
        if (en[3])
        begin
            s3_pcq_reg  <= s2_pc_reg + QUARTER;
            s3_mrom_reg <= SINE_ROM[maddr_next];
            s3_mneg_reg <= mq[1];
        end
        if (en[4])
        begin
            s4_pcq_reg <= s3_pcq_reg;
            s4_km_reg  <= km_next;
        end
        if (en[5])
        begin
            s5_pcq_reg  <= s4_pcq_reg;
            s5_km_reg   <= s4_km_reg;
            s5_prod_reg <= prod_next;
        end
        if (en[6])
        begin
            s6_phase_reg <= phase_next;
            s6_km_reg    <= s5_km_reg;
        end
        if (en[7])
        begin
            s7_crom_reg <= SINE_ROM[caddr_next];
            s7_cneg_reg <= cq[1];
            s7_km_reg   <= s6_km_reg;
        end
        if (en[8])
        begin
            s8_am_reg <= am_next;
            s8_c_reg  <= c_next;
        end
        if (en[9])
        begin
            out_sample_reg <= sample_next;
            out_sat_reg    <= sat_next;
        end
    end

    assign out_valid        = v_reg[NSTAGE];
    assign modulated_sample = out_sample_reg;
    assign saturated        = out_sat_reg;

endmodule

`default_nettype wire
